// ===== sv/b64sd_pkg.sv =====
// Package for the base64 stream decoder: item types, character codes, alphabet lookup.
package b64sd_pkg;

  typedef struct packed {
    logic [7:0] text_char;
    logic       string_start;
  } text_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [1:0]  result_kind;
    logic [11:0] byte_count;
    logic        last_of_run;
  } result_item_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;
  localparam logic [6:0] NOT_SEXTET   = 7'd64;

  localparam int Q_DEPTH     = 8;
  localparam int Q_ADDR_BITS = 3;
  localparam int Q_CNT_BITS  = 4;

  // bit 6 set marks a character outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h47;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'h04;
    end else if (c == CHAR_PLUS) begin
      d = {2'b00, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      d = {2'b00, SEXTET_SLASH};
    end else begin
      d = {1'b0, NOT_SEXTET};
    end
    return d[6:0];
  endfunction

endpackage

// ===== sv/base64_stream_decoder.sv =====
// Top level of the base64 stream decoder: input register, group decode, result queue.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+----------------------------
//   text     | text_valid   | text_stall   | text_item   (text_item_t)
//   result   | result_valid | result_stall | result_item (result_item_t)
//
// One text item per cycle enters the input register while text_stall is low. The
// registered item is decoded combinationally and written as zero to three result
// items into an eight-entry result queue. Results leave the queue one per cycle
// while result_stall is low. text_stall rises while a registered item waits for
// three free queue slots, so a stalled result side backs up into the text side.
// Reset (rst, synchronous) empties the queue and waits for a string start.
module base64_stream_decoder #(
  parameter int COUNT_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_stall,
  input  b64sd_pkg::text_item_t text_item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output b64sd_pkg::result_item_t result_item
);
  import b64sd_pkg::*;

  text_item_t item_q;
  logic       item_vld;
  logic       fire;

  logic [1:0]            grp_pos, grp_pos_next;
  logic [17:0]           held, held_next;
  logic                  third_pad, third_pad_next;
  logic                  plus_pend, plus_pend_next;
  logic                  at_head, at_head_next;
  logic                  finished, finished_next;
  logic [COUNT_BITS-1:0] cnt, cnt_next;

  logic [1:0]            pos_e;
  logic [17:0]           held_e;
  logic                  tp_e;
  logic                  head_e;
  logic [COUNT_BITS-1:0] cnt_e;
  logic                  run;
  logic [7:0]            c;
  logic [6:0]            sx;
  logic [5:0]            v6;
  logic                  bad;
  logic                  pad;
  logic [1:0]            nbytes;
  logic                  fin;
  logic [1:0]            fin_kind;
  logic [1:0]            nres;
  logic [7:0]            bytes [3];
  logic [COUNT_BITS-1:0] kcnt [3];
  logic [COUNT_BITS-1:0] cnt_after;
  result_item_t          res [3];

  result_item_t          mem [Q_DEPTH];
  logic [Q_ADDR_BITS-1:0] wr, rd;
  logic [Q_CNT_BITS-1:0]  qcnt;
  logic                   pop;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
    logic [COUNT_BITS-1:0] one;
    one = {{(COUNT_BITS-1){1'b0}}, 1'b1};
    return (&x) ? x : x + one;
  endfunction

  function automatic logic [11:0] out_count(input logic [COUNT_BITS-1:0] x);
    logic [COUNT_BITS+11:0] e;
    e = {12'd0, x};
    return e[11:0];
  endfunction

  assign fire       = item_vld && (qcnt <= Q_CNT_BITS'(Q_DEPTH - 3));
  assign text_stall = item_vld && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (!text_stall) begin
      item_vld <= text_valid;
    end
    if (!text_stall && text_valid) begin
      item_q <= text_item;
    end
  end

  assign c   = item_q.text_char;
  assign sx  = sextet_of(c);
  assign v6  = sx[5:0];
  assign bad = sx[6];
  assign pad = (c == CHAR_PAD);

  always_comb begin
    grp_pos_next   = grp_pos;
    held_next      = held;
    third_pad_next = third_pad;
    plus_pend_next = plus_pend;
    at_head_next   = at_head;
    finished_next  = finished;
    cnt_next       = cnt;
    pos_e          = grp_pos;
    held_e         = held;
    tp_e           = third_pad;
    head_e         = at_head;
    cnt_e          = cnt;
    run            = 1'b0;
    nbytes         = 2'd0;
    fin            = 1'b0;
    fin_kind       = KIND_OK;

    if (item_q.string_start) begin
      finished_next  = 1'b0;
      plus_pend_next = (c == CHAR_PLUS);
      pos_e          = 2'd0;
      held_e         = 18'd0;
      tp_e           = 1'b0;
      head_e         = 1'b1;
      cnt_e          = '0;
      run            = (c != CHAR_PLUS);
    end else if (finished) begin
      run = 1'b0;
    end else if (plus_pend) begin
      plus_pend_next = 1'b0;
      if (c != CHAR_SPACE) begin
        run    = 1'b1;
        head_e = 1'b0;
        pos_e  = 2'd1;
        held_e = {SEXTET_PLUS, 12'd0};
        tp_e   = 1'b0;
      end
    end else begin
      run = 1'b1;
    end

    if (item_q.string_start || run) begin
      grp_pos_next   = pos_e;
      held_next      = held_e;
      third_pad_next = tp_e;
      at_head_next   = head_e;
      cnt_next       = cnt_e;
    end

    if (run) begin
      if (head_e && c == CHAR_CR) begin
        fin = 1'b1;
      end else if (!head_e && pos_e == 2'd0 && (c == CHAR_NUL || c == CHAR_CR)) begin
        fin = 1'b1;
      end else begin
        at_head_next = 1'b0;
        case (pos_e) inside
          2'd0, 2'd1: begin
            if (bad) begin
              fin      = 1'b1;
              fin_kind = KIND_BAD;
            end else begin
              held_next    = held_e | ((pos_e == 2'd0) ? {v6, 12'd0} : {6'd0, v6, 6'd0});
              grp_pos_next = pos_e + 2'd1;
            end
          end
          2'd2: begin
            if (pad) begin
              third_pad_next = 1'b1;
            end else if (bad) begin
              fin      = 1'b1;
              fin_kind = KIND_BAD;
            end else begin
              held_next = held_e | {12'd0, v6};
            end
            grp_pos_next = 2'd3;
          end
          default: begin
            if (!pad && bad) begin
              fin      = 1'b1;
              fin_kind = KIND_BAD;
            end else begin
              nbytes         = tp_e ? 2'd1 : (pad ? 2'd2 : 2'd3);
              grp_pos_next   = 2'd0;
              held_next      = 18'd0;
              third_pad_next = 1'b0;
              fin            = pad;
            end
          end
        endcase
      end
    end

    if (fin) begin
      finished_next = 1'b1;
    end

    bytes[0] = {held_e[17:12], held_e[11:10]};
    bytes[1] = {held_e[9:6], held_e[5:2]};
    bytes[2] = {held_e[1:0], pad ? 6'd0 : v6};
    kcnt[0]  = sat_inc(cnt_e);
    kcnt[1]  = sat_inc(kcnt[0]);
    kcnt[2]  = sat_inc(kcnt[1]);

    case (nbytes)
      2'd0:    cnt_after = cnt_e;
      2'd1:    cnt_after = kcnt[0];
      2'd2:    cnt_after = kcnt[1];
      default: cnt_after = kcnt[2];
    endcase
    if (run) begin
      cnt_next = cnt_after;
    end

    nres = nbytes + {1'b0, fin};
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < nbytes) begin
        res[i].data_byte   = bytes[i];
        res[i].result_kind = KIND_DATA;
        res[i].byte_count  = out_count(kcnt[i]);
      end else begin
        res[i].data_byte   = 8'd0;
        res[i].result_kind = fin_kind;
        res[i].byte_count  = out_count(cnt_after);
      end
      res[i].last_of_run = (2'(i + 1) == nres);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_pos   <= 2'd0;
      held      <= 18'd0;
      third_pad <= 1'b0;
      plus_pend <= 1'b0;
      at_head   <= 1'b1;
      finished  <= 1'b1;
      cnt       <= '0;
    end else if (fire) begin
      grp_pos   <= grp_pos_next;
      held      <= held_next;
      third_pad <= third_pad_next;
      plus_pend <= plus_pend_next;
      at_head   <= at_head_next;
      finished  <= finished_next;
      cnt       <= cnt_next;
    end
  end

  assign result_valid = (qcnt != '0);
  assign result_item  = mem[rd];
  assign pop          = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nres) begin
          mem[wr + Q_ADDR_BITS'(i)] <= res[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr   <= '0;
      rd   <= '0;
      qcnt <= '0;
    end else begin
      if (fire) begin
        wr <= wr + Q_ADDR_BITS'(nres);
      end
      if (pop) begin
        rd <= rd + {{(Q_ADDR_BITS-1){1'b0}}, 1'b1};
      end
      qcnt <= qcnt + (fire ? Q_CNT_BITS'(nres) : '0) - Q_CNT_BITS'(pop);
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench for the base64 stream decoder: queued text items, inline decode predictor, checker.
module tb_top;
  import b64sd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 190;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_HALF,
    STALL_RUNS
  } stall_mode_e;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           text_valid = 1'b0;
  logic           text_stall;
  text_item_t     text_item = '0;
  logic           result_valid;
  logic           result_stall = 1'b0;
  result_item_t   result_item;

  text_item_t     text_q[$];
  result_item_t   decode_q[$];
  result_item_t   step_out[$];
  int             errors = 0;
  int             quiet_cycles = 0;
  int unsigned    burst_left = 0;
  int unsigned    gap_left = 0;
  int unsigned    mode_left = 0;
  int unsigned    run_left = 0;
  stall_mode_e    stall_mode = STALL_NONE;

  // decoder state as seen by the predictor
  logic [1:0]     grp_pos = 2'd0;
  logic [17:0]    held = 18'd0;
  logic           third_pad = 1'b0;
  logic           plus_hold = 1'b0;
  logic           at_head = 1'b1;
  logic           str_done = 1'b1;
  logic [11:0]    nbytes = 12'd0;

  base64_stream_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_item    (text_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bit 6 flags a character outside the alphabet
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    logic [6:0] v;
    if (c >= "A" && c <= "Z") v = 7'(c - 8'd65);
    else if (c >= "a" && c <= "z") v = 7'(c - 8'd71);
    else if (c >= "0" && c <= "9") v = 7'(c + 8'd4);
    else if (c == CHAR_PLUS) v = {1'b0, SEXTET_PLUS};
    else if (c == CHAR_SLASH) v = {1'b0, SEXTET_SLASH};
    else v = NOT_SEXTET;
    return v;
  endfunction

  function automatic logic [7:0] b64_char(input int unsigned k);
    logic [7:0] c;
    if (k < 26) c = 8'(65 + k);
    else if (k < 52) c = 8'(97 + k - 26);
    else if (k < 62) c = 8'(48 + k - 52);
    else if (k == 62) c = CHAR_PLUS;
    else c = CHAR_SLASH;
    return c;
  endfunction

  function automatic void emit(input logic [7:0] d, input logic [1:0] k);
    result_item_t r;
    r.data_byte   = d;
    r.result_kind = k;
    r.byte_count  = nbytes;
    r.last_of_run = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void emit_byte(input logic [7:0] d);
    if (nbytes != 12'hFFF) nbytes = nbytes + 12'd1;
    emit(d, KIND_DATA);
  endfunction

  function automatic void end_string(input logic [1:0] k);
    str_done = 1'b1;
    emit(8'h00, k);
  endfunction

  function automatic void feed_char(input logic [7:0] c);
    logic [6:0] v;
    logic [5:0] s1, s2, s3, s4;
    v = sextet_value(c);
    if (grp_pos < 2'd2) begin
      if (v[6]) begin
        end_string(KIND_BAD);
      end else begin
        held    = held | (grp_pos == 2'd0 ? {v[5:0], 12'd0} : {6'd0, v[5:0], 6'd0});
        grp_pos = grp_pos + 2'd1;
      end
    end else if (grp_pos == 2'd2) begin
      if (c == CHAR_PAD) begin
        third_pad = 1'b1;
        grp_pos   = 2'd3;
      end else if (v[6]) begin
        end_string(KIND_BAD);
      end else begin
        held    = held | {12'd0, v[5:0]};
        grp_pos = 2'd3;
      end
    end else if (c != CHAR_PAD && v[6]) begin
      end_string(KIND_BAD);
    end else begin
      s1 = held[17:12];
      s2 = held[11:6];
      s3 = held[5:0];
      s4 = (c == CHAR_PAD) ? 6'd0 : v[5:0];
      emit_byte({s1, s2[5:4]});
      if (!third_pad) begin
        emit_byte({s2[3:0], s3[5:2]});
        if (c != CHAR_PAD) emit_byte({s3[1:0], s4});
      end
      grp_pos   = 2'd0;
      held      = '0;
      third_pad = 1'b0;
      if (c == CHAR_PAD) end_string(KIND_OK);
    end
  endfunction

  function automatic void b64_decode_item(input text_item_t it);
    logic         skip;
    result_item_t r;
    step_out.delete();
    skip = 1'b0;
    if (it.string_start) begin
      grp_pos   = 2'd0;
      held      = '0;
      third_pad = 1'b0;
      plus_hold = 1'b0;
      at_head   = 1'b1;
      str_done  = 1'b0;
      nbytes    = '0;
      if (it.text_char == CHAR_PLUS) begin
        plus_hold = 1'b1;
        skip      = 1'b1;
      end
    end else if (str_done) begin
      skip = 1'b1;
    end else if (plus_hold) begin
      plus_hold = 1'b0;
      skip      = 1'b1;
      if (it.text_char != CHAR_SPACE) begin
        at_head = 1'b0;
        feed_char(CHAR_PLUS);
        if (!str_done) feed_char(it.text_char);
      end
    end
    if (!skip) begin
      if (at_head) begin
        if (it.text_char == CHAR_CR) begin
          end_string(KIND_OK);
        end else begin
          at_head = 1'b0;
          feed_char(it.text_char);
        end
      end else if (grp_pos == 2'd0 && (it.text_char == CHAR_NUL || it.text_char == CHAR_CR)) begin
        end_string(KIND_OK);
      end else begin
        feed_char(it.text_char);
      end
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last_of_run = 1'b1;
      step_out.push_back(r);
    end
    foreach (step_out[i]) decode_q.push_back(step_out[i]);
  endfunction

  // driver: bursts of items from text_q with random gaps
  always @(posedge clk) begin : drive
    logic       nv;
    text_item_t ni;
    if (rst) begin
      text_valid <= 1'b0;
    end else begin
      nv = text_valid;
      ni = text_item;
      if (text_valid && !text_stall) begin
        b64_decode_item(text_item);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (text_q.size() > 0) begin
          ni = text_q.pop_front();
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
      text_valid <= nv;
      text_item  <= ni;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor: check accepted results, stall in changing patterns
  always @(posedge clk) begin : monitor
    logic         ns;
    result_item_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (decode_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got kind %0d byte %0d count %0d",
                   $time, result_item.result_kind, result_item.data_byte,
                   result_item.byte_count);
          errors++;
        end else begin
          want = decode_q.pop_front();
          check_field("data_byte", 32'(want.data_byte), 32'(result_item.data_byte));
          check_field("result_kind", 32'(want.result_kind), 32'(result_item.result_kind));
          check_field("byte_count", 32'(want.byte_count), 32'(result_item.byte_count));
          check_field("last_of_run", 32'(want.last_of_run), 32'(result_item.last_of_run));
        end
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(50, 300);
      end else begin
        mode_left = mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: begin
          ns = 1'b0;
        end
        STALL_SPARSE: begin
          ns = ($urandom_range(0, 7) == 0);
        end
        STALL_HALF: begin
          ns = 1'($urandom_range(0, 1));
        end
        default: begin
          if (run_left == 0) begin
            ns       = !result_stall;
            run_left = $urandom_range(1, 30);
          end else begin
            ns       = result_stall;
            run_left = run_left - 1;
          end
        end
      endcase
      result_stall <= ns;
    end
  end

  // watchdog: abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL base64_stream_decoder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add(input logic [7:0] c, input logic s);
    text_item_t it;
    it.text_char    = c;
    it.string_start = s;
    text_q.push_back(it);
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    logic [6:0] v;
    c = 8'($urandom_range(0, 255));
    v = sextet_value(c);
    while (!v[6]) begin
      c = 8'($urandom_range(0, 255));
      v = sextet_value(c);
    end
    return c;
  endfunction

  function automatic logic [7:0] any_b64();
    return b64_char($urandom_range(0, 63));
  endfunction

  // one random string; returns the number of items that reach the decoder
  function automatic int gen_string();
    logic [7:0]  body[$];
    int unsigned groups, ending, part, n;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) add(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      return int'(n);
    end
    case ($urandom_range(0, 5))
      0: begin
        body.push_back(CHAR_PLUS);
        body.push_back(CHAR_SPACE);
      end
      1: begin
        body.push_back(CHAR_PLUS);
      end
      default: begin
      end
    endcase
    groups = $urandom_range(0, 4);
    if (body.size() == 1) begin
      for (int i = 0; i < 3; i++) body.push_back(any_b64());
    end
    for (int g = 0; g < groups; g++) begin
      body.push_back(any_b64());
      body.push_back(any_b64());
      if ($urandom_range(0, 7) == 0) body.push_back(CHAR_PAD);
      else body.push_back(any_b64());
      body.push_back(any_b64());
    end
    ending = $urandom_range(0, 6);
    case (ending)
      0: body.push_back(CHAR_NUL);
      1: body.push_back(CHAR_CR);
      2: begin
        body.push_back(any_b64());
        body.push_back(any_b64());
        body.push_back(CHAR_PAD);
        body.push_back(CHAR_PAD);
      end
      3: begin
        for (int i = 0; i < 3; i++) body.push_back(any_b64());
        body.push_back(CHAR_PAD);
      end
      4: begin
        part = $urandom_range(0, 3);
        for (int i = 0; i < part; i++) body.push_back(any_b64());
        body.push_back(bad_char());
      end
      5: begin
        part = $urandom_range(1, 3);
        for (int i = 0; i < part; i++) body.push_back(any_b64());
        body.push_back(CHAR_NUL);
      end
      default: begin
        part = $urandom_range(0, 3);
        for (int i = 0; i < part; i++) body.push_back(any_b64());
      end
    endcase
    foreach (body[i]) add(body[i], i == 0);
    n = body.size();
    part = $urandom_range(0, 2);
    for (int i = 0; i < part; i++) add(8'($urandom_range(0, 255)), 1'b0);
    return int'(n + part);
  endfunction

  task automatic drain();
    while (text_q.size() != 0 || text_valid) @(negedge clk);
    while (decode_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stimulus
    int issued;
    // plain group then terminator
    add("T", 1'b1); add("W", 1'b0); add("F", 1'b0); add("u", 1'b0); add(CHAR_NUL, 1'b0);
    // plus-space prefix, two pads
    add(CHAR_PLUS, 1'b1); add(CHAR_SPACE, 1'b0);
    add("Q", 1'b0); add("Q", 1'b0); add(CHAR_PAD, 1'b0); add(CHAR_PAD, 1'b0);
    // carriage return at head, then an ignored character
    add(CHAR_CR, 1'b1); add("A", 1'b0);
    // plus as the first character, CR at the group boundary
    add(CHAR_PLUS, 1'b1); add("A", 1'b0); add(CHAR_SLASH, 1'b0); add("9", 1'b0);
    add(CHAR_CR, 1'b0);
    // pad third with valid fourth, then a high code
    add("z", 1'b1); add("0", 1'b0); add(CHAR_PAD, 1'b0); add("Z", 1'b0); add(8'hFF, 1'b0);
    // NUL at head, NUL inside a group, restart mid-string
    add(CHAR_NUL, 1'b1);
    add("a", 1'b1); add(CHAR_NUL, 1'b0);
    add("b", 1'b1); add("c", 1'b1); add("d", 1'b0); add("e", 1'b0); add("f", 1'b0);
    add(CHAR_PAD, 1'b0);

    @(negedge clk);
    while (rst) @(negedge clk);
    drain();

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      issued += gen_string();
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();

    repeat (4) begin
      void'(gen_string());
    end
    drain();
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("PASS base64_stream_decoder");
    end else begin
      $display("FAIL base64_stream_decoder");
    end
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

endmodule

// ===== filelist.f =====
sv/b64sd_pkg.sv
sv/base64_stream_decoder.sv
test/tb_top.sv
